>>> hw/rtl/kbd_pkg.sv
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared types and codes for the K-best distance list: request codes,
// controller states and the control group that drives every list cell.
// ----------------------------------------------------------------------------
package kbd_pkg;

    // Width of the request code field and of the reported fill count.
    localparam int REQ_W   = 2;
    localparam int COUNT_W = 4;

    // Request codes carried by an input item.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Control group broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic clear;
        logic rotate;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/k_best_distance_list_top.sv
// ----------------------------------------------------------------------------
// k_best_distance_list_top
// Keeps the K smallest candidate distances with their point indices in
// ascending order, held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// For an insert or a clear item every cell compares the candidate in
// parallel, so one such item is accepted each cycle while the result side
// keeps up, and its status result appears in the next cycle. A read item
// rotates the list through the head cell of the chain, one filled entry
// per cycle while the result side takes them, and holds the input side
// stalled until the rotation has gone once around all K cells; a read of
// an empty list answers with a status item like an insert. Reset and clear
// set every slot to the maximum distance.
// ----------------------------------------------------------------------------
module k_best_distance_list_top import kbd_pkg::*; #(
    parameter int K          = 8,
    parameter int DIST_BITS  = 32,
    parameter int INDEX_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DIST_BITS-1:0]  i_cand_dist,
    input  logic [INDEX_BITS-1:0] i_cand_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DIST_BITS-1:0]  o_entry_dist,
    output logic [INDEX_BITS-1:0] o_entry_index,
    output logic                  o_entry_valid,
    output logic [COUNT_W-1:0]    o_filled_count,
    output logic [DIST_BITS-1:0]  o_worst_dist,
    output logic                  o_last
);

    localparam int FILL_W = $clog2(K + 1);

    // Cell chain wiring.
    logic [DIST_BITS-1:0]  w_slot_dist  [K];
    logic [INDEX_BITS-1:0] w_slot_index [K];
    logic [DIST_BITS-1:0]  w_next_dist  [K];
    t_cell_ctrl            w_ctrl;

    // Control and result registers.
    t_state                r_state,        n_state;
    logic [FILL_W-1:0]     r_fill,         n_fill;
    logic [FILL_W-1:0]     r_cnt,          n_cnt;
    logic [DIST_BITS-1:0]  r_read_worst,   n_read_worst;
    logic                  r_ovalid,       n_ovalid;
    logic [DIST_BITS-1:0]  r_entry_dist,   n_entry_dist;
    logic [INDEX_BITS-1:0] r_entry_index,  n_entry_index;
    logic                  r_entry_valid,  n_entry_valid;
    logic [COUNT_W-1:0]    r_filled_count, n_filled_count;
    logic [DIST_BITS-1:0]  r_worst_dist,   n_worst_dist;
    logic                  r_last,         n_last;

    logic in_acc;
    logic out_free;
    logic cand_fits;
    logic emit_read;

    // Chain of list cells; the head compares against zero so it never
    // shifts in, and the tail takes from the head during rotation.
    for (genvar g = 0; g < K; g++) begin : g_cell
        logic [DIST_BITS-1:0]  w_prev_dist;
        logic [INDEX_BITS-1:0] w_prev_index;

        if (g == 0) begin : g_head
            assign w_prev_dist  = '0;
            assign w_prev_index = '0;
        end else begin : g_body
            assign w_prev_dist  = w_slot_dist[g-1];
            assign w_prev_index = w_slot_index[g-1];
        end

        kbd_cell #(
            .DIST_BITS  (DIST_BITS),
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_cand_dist  (i_cand_dist),
            .i_cand_index (i_cand_index),
            .i_prev_dist  (w_prev_dist),
            .i_prev_index (w_prev_index),
            .i_next_dist  (w_slot_dist[(g + 1) % K]),
            .i_next_index (w_slot_index[(g + 1) % K]),
            .o_slot_dist  (w_slot_dist[g]),
            .o_slot_index (w_slot_index[g]),
            .o_next_dist  (w_next_dist[g])
        );
    end

    // Handshake: new items only while idle and while the result register
    // is empty or being taken.
    assign out_free  = !r_ovalid || !i_stall;
    assign o_stall   = (r_state != ST_IDLE) || !out_free;
    assign in_acc    = i_valid && !o_stall;
    assign cand_fits = i_cand_dist < w_slot_dist[K-1];

    // Next state, cell control and result register loading.
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_cnt          = r_cnt;
        n_read_worst   = r_read_worst;
        n_ovalid       = r_ovalid && i_stall;
        n_entry_dist   = r_entry_dist;
        n_entry_index  = r_entry_index;
        n_entry_valid  = r_entry_valid;
        n_filled_count = r_filled_count;
        n_worst_dist   = r_worst_dist;
        n_last         = r_last;
        w_ctrl         = '0;
        emit_read      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if ((i_req_type == REQ_READ) && (r_fill != '0)) begin
                        // Start streaming; the bound is captured now since
                        // the tail slot moves during rotation.
                        n_state      = ST_READ;
                        n_cnt        = '0;
                        n_read_worst = w_slot_dist[K-1];
                    end else begin
                        w_ctrl.insert = (i_req_type == REQ_INSERT);
                        w_ctrl.clear  = (i_req_type == REQ_CLEAR);
                        if (w_ctrl.clear) begin
                            n_fill = '0;
                        end else if (w_ctrl.insert && cand_fits
                                     && (r_fill < FILL_W'(K))) begin
                            n_fill = r_fill + FILL_W'(1);
                        end
                        // Status result taken after the update.
                        n_ovalid       = 1'b1;
                        n_entry_dist   = '0;
                        n_entry_index  = '0;
                        n_entry_valid  = 1'b0;
                        n_filled_count = COUNT_W'(n_fill);
                        n_worst_dist   = w_next_dist[K-1];
                        n_last         = 1'b1;
                    end
                end
            end
            ST_READ: begin
                // Filled entries wait for the result register; the rest of
                // the rotation that restores the order runs freely.
                emit_read     = (r_cnt < r_fill) && out_free;
                w_ctrl.rotate = (r_cnt < r_fill) ? out_free : 1'b1;
                if (emit_read) begin
                    n_ovalid       = 1'b1;
                    n_entry_dist   = w_slot_dist[0];
                    n_entry_index  = w_slot_index[0];
                    n_entry_valid  = 1'b1;
                    n_filled_count = COUNT_W'(r_fill);
                    n_worst_dist   = r_read_worst;
                    n_last         = (r_cnt + FILL_W'(1)) == r_fill;
                end
                if (w_ctrl.rotate) begin
                    n_cnt = r_cnt + FILL_W'(1);
                    if (r_cnt == FILL_W'(K - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Result payload and captured bound.
    always_ff @(posedge i_clk) begin
        r_read_worst   <= n_read_worst;
        r_entry_dist   <= n_entry_dist;
        r_entry_index  <= n_entry_index;
        r_entry_valid  <= n_entry_valid;
        r_filled_count <= n_filled_count;
        r_worst_dist   <= n_worst_dist;
        r_last         <= n_last;
    end

    assign o_valid        = r_ovalid;
    assign o_entry_dist   = r_entry_dist;
    assign o_entry_index  = r_entry_index;
    assign o_entry_valid  = r_entry_valid;
    assign o_filled_count = r_filled_count;
    assign o_worst_dist   = r_worst_dist;
    assign o_last         = r_last;

    // Ordering of the chain, checked while no rotation is in flight.
    logic w_sorted;
    always_comb begin
        w_sorted = 1'b1;
        for (int i = 0; i + 1 < K; i++) begin
            if (w_slot_dist[i] > w_slot_dist[i+1]) begin
                w_sorted = 1'b0;
            end
        end
    end

    // The fill level never passes the list length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(K))
        else $error("fill level above list length");

    // Outside a read the slots stay in ascending order.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> w_sorted)
        else $error("list out of order");

    // A candidate not below the bound leaves the fill level unchanged.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req_type == REQ_INSERT) && !cand_fits)
        |=> (r_fill == $past(r_fill)))
        else $error("dropped candidate changed fill level");

    // A read in progress holds off new items.
    a_read_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> o_stall)
        else $error("item accepted during read out");

    // A streamed entry marked last ends at the fill level.
    a_last_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_read && ((r_cnt + FILL_W'(1)) == r_fill) |=> (o_last && o_entry_valid))
        else $error("last entry not marked");

endmodule

>>> hw/rtl/kbd_cell.sv
// ----------------------------------------------------------------------------
// kbd_cell
// One slot of the sorted list. On insert it compares the candidate with its
// own entry and with the entry of the cell before it, and either keeps its
// entry, takes the candidate, or takes the neighbor's entry as the list
// shifts down. During read out it takes the entry of the cell after it, so
// the whole list rotates through the head cell.
// ----------------------------------------------------------------------------
module kbd_cell import kbd_pkg::*; #(
    parameter int DIST_BITS  = 32,
    parameter int INDEX_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [DIST_BITS-1:0]  i_cand_dist,
    input  logic [INDEX_BITS-1:0] i_cand_index,
    input  logic [DIST_BITS-1:0]  i_prev_dist,
    input  logic [INDEX_BITS-1:0] i_prev_index,
    input  logic [DIST_BITS-1:0]  i_next_dist,
    input  logic [INDEX_BITS-1:0] i_next_index,
    output logic [DIST_BITS-1:0]  o_slot_dist,
    output logic [INDEX_BITS-1:0] o_slot_index,
    output logic [DIST_BITS-1:0]  o_next_dist
);

    logic [DIST_BITS-1:0]  r_dist;
    logic [INDEX_BITS-1:0] r_index;
    logic [DIST_BITS-1:0]  n_dist;
    logic [INDEX_BITS-1:0] n_index;

    // Next entry of this slot. A candidate equal to an older entry goes
    // behind it, so both compares are strict.
    always_comb begin
        n_dist  = r_dist;
        n_index = r_index;
        if (i_ctrl.clear) begin
            n_dist  = '1;
            n_index = '0;
        end else if (i_ctrl.rotate) begin
            n_dist  = i_next_dist;
            n_index = i_next_index;
        end else if (i_ctrl.insert && (i_cand_dist < r_dist)) begin
            if (i_cand_dist < i_prev_dist) begin
                n_dist  = i_prev_dist;
                n_index = i_prev_index;
            end else begin
                n_dist  = i_cand_dist;
                n_index = i_cand_index;
            end
        end
    end

    // Slot register; an empty slot holds the maximum distance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= '1;
            r_index <= '0;
        end else begin
            r_dist  <= n_dist;
            r_index <= n_index;
        end
    end

    assign o_slot_dist  = r_dist;
    assign o_slot_index = r_index;
    assign o_next_dist  = n_dist;

endmodule

>>> tb/sv/tb_k_best_distance_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_k_best_distance_list_top
// Self-checking bench for the K-best distance list. A scoreboard class keeps
// its own sorted copy of the list, predicts the status and read-out items
// for every accepted request, and compares each accepted result item field
// by field. Stimulus is a directed opening followed by random requests, with
// random idle bursts on both handshakes.
// ----------------------------------------------------------------------------
import kbd_pkg::*;

localparam int LIST_K  = 8;
localparam int DIST_W  = 32;
localparam int INDEX_W = 20;

// Request code that the block answers with a plain status item.
localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

typedef struct packed {
    logic [DIST_W-1:0]  ent_dist;
    logic [INDEX_W-1:0] index;
    logic               entry_valid;
    logic [COUNT_W-1:0] count;
    logic [DIST_W-1:0]  worst;
    logic               last;
} t_list_result;

class kbest_scoreboard;
    logic [DIST_W-1:0]  slot_dist [LIST_K];
    logic [INDEX_W-1:0] slot_index[LIST_K];
    int                 fill;
    t_list_result       expected_q[$];
    int                 errors;
    int                 n_checked;
    int                 n_insert, n_kept, n_read, n_clear, n_unused;

    function new();
        clear_list();
    endfunction

    function void clear_list();
        for (int i = 0; i < LIST_K; i++) begin
            slot_dist[i]  = '1;
            slot_index[i] = '0;
        end
        fill = 0;
    endfunction

    function void push_result(logic [DIST_W-1:0] distance, logic [INDEX_W-1:0] index,
                              logic entry_valid, logic last);
        t_list_result r;
        r.ent_dist    = distance;
        r.index       = index;
        r.entry_valid = entry_valid;
        r.count       = COUNT_W'(fill);
        r.worst       = slot_dist[LIST_K-1];
        r.last        = last;
        expected_q    = {expected_q, r};
    endfunction

    // Sorted insertion: larger entries slide down, ties stay behind older ones.
    function void insert_candidate(logic [DIST_W-1:0] distance,
                                   logic [INDEX_W-1:0] index);
        int pos;
        if (distance >= slot_dist[LIST_K-1]) return;
        n_kept++;
        if (fill < LIST_K) fill++;
        pos = fill - 1;
        while (pos > 0 && distance < slot_dist[pos-1]) begin
            slot_dist[pos]  = slot_dist[pos-1];
            slot_index[pos] = slot_index[pos-1];
            pos--;
        end
        slot_dist[pos]  = distance;
        slot_index[pos] = index;
    endfunction

    // Called once per accepted input item.
    function void note_input(logic [REQ_W-1:0] req, logic [DIST_W-1:0] distance,
                             logic [INDEX_W-1:0] index);
        case (req)
            REQ_READ: begin
                n_read++;
                if (fill == 0) begin
                    push_result('0, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++)
                        push_result(slot_dist[i], slot_index[i], 1'b1, i == fill - 1);
                end
            end
            REQ_INSERT: begin
                n_insert++;
                insert_candidate(distance, index);
                push_result('0, '0, 1'b0, 1'b1);
            end
            REQ_CLEAR: begin
                n_clear++;
                clear_list();
                push_result('0, '0, 1'b0, 1'b1);
            end
            default: begin
                n_unused++;
                push_result('0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function string show(t_list_result r);
        return $sformatf("dist=%h index=%h valid=%b count=%0d worst=%h last=%b",
                         r.ent_dist, r.index, r.entry_valid, r.count, r.worst, r.last);
    endfunction

    function void note_failure(string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Called once per accepted result item.
    function void check_result(t_list_result got);
        t_list_result want;
        string        bad;
        if (expected_q.size() == 0) begin
            note_failure({"result with nothing expected: ", show(got)});
            return;
        end
        want = expected_q.pop_front();
        bad  = "";
        if (got.ent_dist != want.ent_dist)       bad = {bad, " entry_dist"};
        if (got.index != want.index)             bad = {bad, " entry_index"};
        if (got.entry_valid != want.entry_valid) bad = {bad, " entry_valid"};
        if (got.count != want.count)             bad = {bad, " filled_count"};
        if (got.worst != want.worst)             bad = {bad, " worst_dist"};
        if (got.last != want.last)               bad = {bad, " last"};
        if (bad != "")
            note_failure($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                                   n_checked, bad, show(want), show(got)));
        n_checked++;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_k_best_distance_list_top;

    localparam int CYCLE_LIMIT = 200000;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_stall;
    logic [REQ_W-1:0]    i_req_type   = REQ_INSERT;
    logic [DIST_W-1:0]   i_cand_dist  = '0;
    logic [INDEX_W-1:0]  i_cand_index = '0;
    logic                o_valid;
    logic                i_stall      = 1'b0;
    logic [DIST_W-1:0]   o_entry_dist;
    logic [INDEX_W-1:0]  o_entry_index;
    logic                o_entry_valid;
    logic [COUNT_W-1:0]  o_filled_count;
    logic [DIST_W-1:0]   o_worst_dist;
    logic                o_last;

    kbest_scoreboard sb;
    bit              idle_on = 1'b1;
    int              cycle_count = 0;

    k_best_distance_list_top #(
        .K          (LIST_K),
        .DIST_BITS  (DIST_W),
        .INDEX_BITS (INDEX_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_cand_dist    (i_cand_dist),
        .i_cand_index   (i_cand_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_entry_dist   (o_entry_dist),
        .o_entry_index  (o_entry_index),
        .o_entry_valid  (o_entry_valid),
        .o_filled_count (o_filled_count),
        .o_worst_dist   (o_worst_dist),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.pending());
            $display("tb_k_best_distance_list_top failed");
            $finish;
        end
    end

    // Result side backpressure in random bursts while idling is enabled.
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Every accepted result item goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_entry_dist, o_entry_index, o_entry_valid,
                              o_filled_count, o_worst_dist, o_last});
    end

    // Present one item, with an optional idle burst first, and hold it until taken.
    task automatic send_item(input logic [REQ_W-1:0] req,
                             input logic [DIST_W-1:0] distance,
                             input logic [INDEX_W-1:0] index);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_cand_dist  <= distance;
        i_cand_index <= index;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(req, distance, index);
    endtask

    initial begin
        int                 kind;
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;

        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty read, drops at the bound, ties, overflow of the list.
        send_item(REQ_READ,   '0,   '0);
        send_item(REQ_INSERT, '1,   20'd5);
        send_item(REQ_INSERT, 100,  20'd1);
        send_item(REQ_INSERT, 50,   20'd2);
        send_item(REQ_INSERT, 100,  20'd3);
        send_item(REQ_INSERT, '0,   '1);
        send_item(REQ_INSERT, 75,   20'd4);
        send_item(REQ_INSERT, 100,  20'd6);
        send_item(REQ_INSERT, 20,   20'd7);
        send_item(REQ_INSERT, 300,  20'd8);
        send_item(REQ_INSERT, 300,  20'd9);
        send_item(REQ_INSERT, 1000, 20'd10);
        send_item(REQ_INSERT, 60,   20'd11);
        send_item(REQ_UNUSED, DIST_W'($urandom), INDEX_W'($urandom));
        send_item(REQ_READ,   DIST_W'($urandom), INDEX_W'($urandom));
        send_item(REQ_INSERT, 32'hFFFF_FFFE, 20'd12);
        send_item(REQ_CLEAR,  DIST_W'($urandom), INDEX_W'($urandom));
        send_item(REQ_READ,   '0,   '0);
        send_item(REQ_INSERT, 32'hFFFF_FFFE, '1);
        send_item(REQ_INSERT, '1,   20'd13);
        send_item(REQ_READ,   '0,   '0);
        send_item(REQ_CLEAR,  '0,   '0);

        // Random part: mostly inserts, with clusters of small distances for ties.
        for (int n = 0; n < 170; n++) begin
            idle_on = (n < 130) && ((n / 25) % 3 != 2);
            kind    = $urandom_range(0, 99);
            index   = INDEX_W'($urandom);
            case ($urandom_range(0, 4))
                0, 1:    distance = DIST_W'($urandom_range(0, 63));
                2, 3:    distance = DIST_W'($urandom);
                default: distance = ~DIST_W'($urandom_range(0, 15));
            endcase
            if (kind < 78)      send_item(REQ_INSERT, distance, index);
            else if (kind < 90) send_item(REQ_READ,   distance, index);
            else if (kind < 95) send_item(REQ_CLEAR,  distance, index);
            else                send_item(REQ_UNUSED, distance, index);
        end
        i_valid <= 1'b0;

        // Drain, then a short quiet window to catch stray result items.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("requests: %0d inserts (%0d kept), %0d reads, %0d clears, %0d unused codes",
                 sb.n_insert, sb.n_kept, sb.n_read, sb.n_clear, sb.n_unused);
        $display("result items checked: %0d, failures: %0d", sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_k_best_distance_list_top passed");
        end else begin
            $display("tb_k_best_distance_list_top failed");
        end
        $finish;
    end

endmodule
